### hdl/scf_pkg.sv
// Shared types and constants of the speech command framer.
package scf_pkg;

  // Frame constants
  localparam logic [7:0] HeadByte   = 8'hFD;
  localparam logic [7:0] CmdSpeak   = 8'h01;
  localparam logic [7:0] CmdVolume  = 8'h03;
  localparam logic [7:0] MusicByte  = 8'h00;
  localparam logic [7:0] ZeroByte   = 8'h00;
  localparam logic [7:0] VolLenLo   = 8'h03;
  localparam logic [7:0] VolLimit   = 8'd10;
  localparam logic [7:0] LenOffset  = 8'd3;
  // Longest speak text accepted (at most 252 so the length high byte stays zero)
  localparam logic [7:0] MaxText    = 8'd200;

  // Request types
  localparam logic ReqSpeak  = 1'b0;
  localparam logic ReqVolume = 1'b1;

  // One classified job for the back end
  typedef struct packed {
    logic       is_volume;  // volume frame
    logic       has_head;   // speak: emit the five-byte head first
    logic       last;       // speak: closing checksum follows the text byte
    logic [7:0] data;       // speak: text byte
    logic [7:0] aux;        // speak: length low byte; volume: clamped volume
    logic [7:0] xsum;       // speak: checksum for the closing byte
  } job_t;

  // Front to queue
  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

  // Queue to back
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage

### hdl/scf_if.sv
// Request and result channel interfaces of the speech command framer.
interface scf_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic [7:0] text_length;

  modport source (output valid, output req_type, output data_byte, output text_length,
                  input ready);
  modport sink   (input valid, input req_type, input data_byte, input text_length,
                  output ready);
endinterface

interface scf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

### hdl/speech_command_framer.sv
// Top level of the speech command framer.
//
// Requests enter on in_i (valid/ready): a speak text byte or a set volume request.
// The first text byte of a message carries the length and opens the frame with
// the head 0xFD, 0x00, length+3, 0x01, 0x00; each text byte follows, and the
// last one is followed by the XOR checksum, flagged by frame_end. Empty or
// overlong messages are discarded whole. A volume request gives a six-byte frame.
// Frame bytes leave on out_o (valid/ready), one byte per cycle at most.
// The first byte caused by an accepted request is registered in the job queue
// and then in the output register. A request is taken whenever the queue has
// room, so requests keep coming in while earlier frames still drain; the rate
// is one output byte per cycle while the receiver is ready: a text byte gives
// one frame byte, a message's first six, its last one more, a volume request six.
// A receiver stall holds the output register and the back end; the front end
// keeps accepting until the queue of QueueDepth jobs fills, then drops ready.
// Reset clears message state, the queue and the output valid.
module speech_command_framer
  import scf_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scf_req_if.sink    in_i,
  scf_res_if.source  out_o
);

  push_t push;
  head_t head;
  logic  full;
  logic  pop;

  scf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push)
  );

  scf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  scf_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

### hdl/scf_front.sv
// Front end: accepts requests, tracks message state and classifies them into jobs.
module scf_front
  import scf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  scf_req_if.sink     in_i,
  input  logic        full_i,
  output push_t       push_o
);

  logic       in_message_q, in_message_d;
  logic       dropping_q, dropping_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] running_xor_q, running_xor_d;

  logic       accept;
  logic [7:0] len_lo;
  logic [7:0] left_base;
  logic [7:0] left_next;
  logic [7:0] xor_base;
  logic [7:0] xor_next;
  logic [7:0] vol;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  assign len_lo    = in_i.text_length + LenOffset;
  assign left_base = in_message_q ? bytes_left_q : in_i.text_length;
  assign left_next = left_base - 8'd1;
  assign xor_base  = in_message_q ? running_xor_q : (ZeroByte ^ len_lo ^ CmdSpeak ^ MusicByte);
  assign xor_next  = xor_base ^ in_i.data_byte;
  assign vol       = (in_i.data_byte > VolLimit) ? VolLimit : in_i.data_byte;

  // Classification and state update
  always_comb begin
    in_message_d   = in_message_q;
    dropping_d     = dropping_q;
    bytes_left_d   = bytes_left_q;
    running_xor_d  = running_xor_q;
    push_o.push    = 1'b0;
    push_o.job     = '0;
    push_o.job.data = in_i.data_byte;
    if (accept) begin
      if (in_i.req_type == ReqVolume) begin
        // ignored while a message is open or being dropped
        if (!in_message_q && !dropping_q) begin
          push_o.push          = 1'b1;
          push_o.job.is_volume = 1'b1;
          push_o.job.aux       = vol;
        end
      end else if (dropping_q) begin
        bytes_left_d = bytes_left_q - 8'd1;
        if (bytes_left_d == 8'd0) begin
          dropping_d = 1'b0;
        end
      end else if (!in_message_q && in_i.text_length == 8'd0) begin
        // empty message: nothing happens
      end else if (!in_message_q && in_i.text_length > MaxText) begin
        bytes_left_d = left_next;
        dropping_d   = (left_next != 8'd0);
      end else begin
        push_o.push         = 1'b1;
        push_o.job.has_head = !in_message_q;
        push_o.job.aux      = len_lo;
        push_o.job.xsum     = xor_next;
        push_o.job.last     = (left_next == 8'd0);
        bytes_left_d        = left_next;
        if (left_next == 8'd0) begin
          in_message_d  = 1'b0;
          running_xor_d = 8'd0;
        end else begin
          in_message_d  = 1'b1;
          running_xor_d = xor_next;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_message_q  <= 1'b0;
      dropping_q    <= 1'b0;
      bytes_left_q  <= 8'd0;
      running_xor_q <= 8'd0;
    end else begin
      in_message_q  <= in_message_d;
      dropping_q    <= dropping_d;
      bytes_left_q  <= bytes_left_d;
      running_xor_q <= running_xor_d;
    end
  end

endmodule

### hdl/scf_queue.sv
// Short job queue between the front and back ends.
module scf_queue
  import scf_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  logic  pop_i,
  output logic  full_o,
  output head_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_o.valid = (count_q != '0);
  assign head_o.job   = mem_q[rd_ptr_q];
  assign do_push      = push_i.push && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

### hdl/scf_back.sv
// Back end: turns queued jobs into registered frame bytes, one per cycle unless stalled.
module scf_back
  import scf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  head_t   head_i,
  output logic    pop_o,
  scf_res_if.source out_o
);

  // Byte positions within a frame
  localparam logic [2:0] StepHead  = 3'd0;
  localparam logic [2:0] StepLenHi = 3'd1;
  localparam logic [2:0] StepLenLo = 3'd2;
  localparam logic [2:0] StepCmd   = 3'd3;
  localparam logic [2:0] StepMusic = 3'd4;
  localparam logic [2:0] StepText  = 3'd5;
  localparam logic [2:0] StepSum   = 3'd6;

  logic [2:0] step_q, step_d;
  logic [2:0] step;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       frame_end_q;
  logic       advance;
  logic       done;
  logic [7:0] byte_sel;
  logic       end_sel;

  assign advance = head_i.valid && (!out_valid_q || out_o.ready);
  assign pop_o   = advance && done;

  // A speak job without a head starts at its text byte
  assign step = (step_q == StepHead && !head_i.job.is_volume && !head_i.job.has_head)
                ? StepText : step_q;

  // Byte selection
  always_comb begin
    byte_sel = ZeroByte;
    end_sel  = 1'b0;
    done     = 1'b0;
    if (head_i.job.is_volume) begin
      unique case (step)
        StepHead:  byte_sel = HeadByte;
        StepLenHi: byte_sel = ZeroByte;
        StepLenLo: byte_sel = VolLenLo;
        StepCmd:   byte_sel = CmdVolume;
        StepMusic: byte_sel = head_i.job.aux;
        default: begin
          byte_sel = ZeroByte ^ VolLenLo ^ CmdVolume ^ head_i.job.aux;
          end_sel  = 1'b1;
          done     = 1'b1;
        end
      endcase
    end else begin
      unique case (step)
        StepHead:  byte_sel = HeadByte;
        StepLenHi: byte_sel = ZeroByte;
        StepLenLo: byte_sel = head_i.job.aux;
        StepCmd:   byte_sel = CmdSpeak;
        StepMusic: byte_sel = MusicByte;
        StepText: begin
          byte_sel = head_i.job.data;
          done     = !head_i.job.last;
        end
        default: begin
          byte_sel = head_i.job.xsum;
          end_sel  = 1'b1;
          done     = 1'b1;
        end
      endcase
    end
  end

  assign step_d = done ? StepHead : step + 3'd1;

  // Step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StepHead;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        step_q <= step_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q  <= byte_sel;
      frame_end_q <= end_sel;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.frame_end = frame_end_q;

endmodule
